// ----- design/positional_list_engine_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Clocked, reset-qualified property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define PLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positional list engine: same-cycle check failed");

// next-cycle implication
`define PLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("positional list engine: next-cycle check failed");

`endif

// ----- design/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional list engine package
// Store sizing, command codes and word layouts shared by the design files.
// ----------------------------------------------------------------------------
package ple_pkg;

    // store depth and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > 7) ? CNT_W : 7) + 1;

    // field widths
    localparam int CMD_W   = 2;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    // stream word widths (padded to whole bytes)
    localparam int IN_BITS  = CMD_W + POS_W + DATA_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + DATA_W + COUNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

endpackage

// ----- design/positional_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit values with positional insert/get/update/remove.
// ----------------------------------------------------------------------------
// One command word in, one result word out. The list lives in a single-port-
// write, registered-read RAM of CAPACITY words; a small sequencer drives one
// +/-1 address unit over it. Update, a refused command and removing the last
// entry go from the execute state straight to the result state; get and an
// insert at the end first pass a further state (read capture or new write).
// Otherwise insert and remove move each later entry with a read then a write,
// and insert then writes the new entry. The input is ready only while the
// sequencer is idle, so the next command can be taken in the cycle after the
// result is loaded. A finished result waits in the output register and does
// not hold off the next command; only a second finished result keeps the
// sequencer in its last state until the first is taken.
// No clearing pass after reset: entries are reachable only once written.
// ----------------------------------------------------------------------------
module positional_list_engine_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // slave word: cmd[1:0], position[8:2], data_in[40:9], zero pad above
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [ple_pkg::IN_W-1:0]  s_axis_tdata,
    // master word: ok[0], read_data[32:1], count[39:33]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [ple_pkg::OUT_W-1:0] m_axis_tdata
);
    import ple_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SH_RD = 3'd2;
    localparam logic [2:0] S_SH_WR = 3'd3;
    localparam logic [2:0] S_GET   = 3'd4;
    localparam logic [2:0] S_NEW   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          r_state, n_state;
    t_cnt                r_count, n_count;
    logic [CMD_W-1:0]    r_cmd;
    t_idx                r_idx;
    logic [DATA_W-1:0]   r_data;
    logic                r_ok;
    logic [DATA_W-1:0]   r_rd, n_rd;
    t_idx                r_addr, n_addr;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    // memory
    logic [DATA_W-1:0]   r_mem [CAPACITY];
    logic [DATA_W-1:0]   r_mem_q;
    logic                w_we;
    t_idx                w_waddr;
    t_idx                w_raddr;
    logic [DATA_W-1:0]   w_wdata;

    // input field split
    logic [CMD_W-1:0]    w_cmd;
    logic [POS_W-1:0]    w_pos;
    logic [DATA_W-1:0]   w_din;
    logic                w_accept;
    logic                w_ok;
    logic [CMP_W-1:0]    w_pos_c;
    logic [CMP_W-1:0]    w_cnt_c;

    // shared +/-1 address unit
    logic                w_up;
    t_idx                w_step;
    logic                w_load;

    assign w_cmd = s_axis_tdata[CMD_W-1:0];
    assign w_pos = s_axis_tdata[CMD_W+POS_W-1:CMD_W];
    assign w_din = s_axis_tdata[IN_BITS-1:CMD_W+POS_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // range check against the current count
    assign w_pos_c = CMP_W'(w_pos);
    assign w_cnt_c = CMP_W'(r_count);
    always_comb begin
        if (w_cmd == CMD_INSERT) begin
            w_ok = (r_count != CNT_W'(CAPACITY)) && (w_pos != '0)
                && (w_pos_c <= w_cnt_c + CMP_W'(1));
        end else begin
            w_ok = (w_pos != '0) && (w_pos_c <= w_cnt_c);
        end
    end

    // insert walks down from the top, remove walks up
    assign w_up   = (r_cmd == CMD_REMOVE);
    assign w_step = w_up ? (r_addr + t_idx'(1)) : (r_addr - t_idx'(1));

    // result load once the output register is free
    assign w_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_addr  = r_addr;
        n_rd    = r_rd;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_data;
        w_raddr = r_addr;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                    n_rd    = '0;
                end
            end
            S_EXEC: begin
                w_raddr = r_idx;
                if (!r_ok) begin
                    n_state = S_DONE;
                end else begin
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            if (CNT_W'(r_idx) == r_count) begin
                                n_state = S_NEW;
                            end else begin
                                n_addr  = t_idx'(r_count - CNT_W'(1));
                                n_state = S_SH_RD;
                            end
                        end
                        CMD_GET: begin
                            n_state = S_GET;
                        end
                        CMD_UPDATE: begin
                            w_we    = 1'b1;
                            n_state = S_DONE;
                        end
                        CMD_REMOVE: begin
                            if ((CNT_W'(r_idx) + CNT_W'(1)) == r_count) begin
                                n_count = r_count - CNT_W'(1);
                                n_state = S_DONE;
                            end else begin
                                n_addr  = r_idx + t_idx'(1);
                                n_state = S_SH_RD;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SH_RD: begin
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                // move the word just read one place along
                w_we    = 1'b1;
                w_waddr = w_up ? (r_addr - t_idx'(1)) : (r_addr + t_idx'(1));
                w_wdata = r_mem_q;
                if (w_up) begin
                    if (r_addr == t_idx'(r_count - CNT_W'(1))) begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_DONE;
                    end else begin
                        n_addr  = w_step;
                        n_state = S_SH_RD;
                    end
                end else begin
                    if (r_addr == r_idx) begin
                        n_state = S_NEW;
                    end else begin
                        n_addr  = w_step;
                        n_state = S_SH_RD;
                    end
                end
            end
            S_GET: begin
                n_rd    = r_mem_q;
                n_state = S_DONE;
            end
            S_NEW: begin
                w_we    = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= w_cmd;
            r_idx  <= t_idx'(POS_W'(w_pos - POS_W'(1)));
            r_data <= w_din;
            r_ok   <= w_ok;
        end
        r_addr <= n_addr;
        r_rd   <= n_rd;
        if (w_load) begin
            r_out_data <= OUT_W'({COUNT_W'(r_count), r_rd, r_ok});
        end
    end

    // list store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_mem_q <= r_mem[w_raddr];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- design/ple_checker.sv -----
// ----------------------------------------------------------------------------
// Positional list engine port checker
// Watches the top level's stream ports; bound to every instance of the top.
// ----------------------------------------------------------------------------
`include "positional_list_engine_top_assert.svh"

module ple_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [ple_pkg::OUT_W-1:0] i_m_tdata
);
    import ple_pkg::*;

    logic                w_ok;
    logic [DATA_W-1:0]   w_rd;
    logic [COUNT_W-1:0]  w_cnt;

    assign w_ok  = i_m_tdata[0];
    assign w_rd  = i_m_tdata[DATA_W:1];
    assign w_cnt = i_m_tdata[OUT_BITS-1:DATA_W+1];

    // a stalled result word holds
    `PLE_ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata))

    // the sequencer is busy in the cycle after taking a command
    `PLE_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && i_s_tready, !i_s_tready)

    // a refused command never returns data
    `PLE_ASSERT_NOW(a_fail_no_data, i_m_tvalid && !w_ok, w_rd == '0)

    // count never passes the store depth
    `PLE_ASSERT_NOW(a_count_bound, i_m_tvalid, 32'(w_cnt) <= 32'(CAPACITY))

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
